// ===== rtl/rlbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbtc_pkg
// Shared types, widths, constants and helpers for the run-length bounded
// two-color segmentation block.
// ----------------------------------------------------------------------------
package rlbtc_pkg;

  // field widths
  localparam int unsigned IN_COST_W = 11;
  localparam int unsigned COST_W    = 21;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [IN_COST_W-1:0] in_cost_t;
  typedef logic [COST_W-1:0]    cost_t;
  // candidate word: MSB set means "nothing reachable", so a plain min works
  typedef logic [COST_W:0]      cand_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN = 1'b1;

  // register reset values
  localparam cfg_t MIN_RUN_RESET = 7'd1;
  localparam cfg_t MAX_RUN_RESET = 7'd64;

  // empty candidate
  localparam cand_t CAND_NONE = {1'b1, {COST_W{1'b0}}};

  // per-cycle operation for every cell of a chain
  typedef struct packed {
    logic init;   // load first column
    logic shift;  // advance one column
    logic scan;   // move the running minimum one cell along
  } cell_ctrl_t;

  // add a column cost, saturating at all ones
  function automatic cost_t sat_add(input cost_t a, input in_cost_t b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W + 1 - IN_COST_W){1'b0}}, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/rlbtc_if.sv =====
// ----------------------------------------------------------------------------
// rlbtc_col_if / rlbtc_res_if
// Valid/ready channels for column beats in and result beats out.
// ----------------------------------------------------------------------------
interface rlbtc_col_if import rlbtc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_cost_t cost_white;
  in_cost_t cost_black;
  logic     last_column;

  modport source (output valid, cost_white, cost_black, last_column, input ready);
  modport sink   (input valid, cost_white, cost_black, last_column, output ready);
endinterface

interface rlbtc_res_if import rlbtc_pkg::*; ();
  logic  valid;
  logic  ready;
  cost_t min_cost;
  logic  infeasible;

  modport source (output valid, min_cost, infeasible, input ready);
  modport sink   (input valid, min_cost, infeasible, output ready);
endinterface

// ===== rtl/run_length_bounded_two_color_dp.sv =====
// Sequence: a first column is accepted, then loaded into the cells (init); a
//   later column is accepted, then a min scan runs along the cell rows, then
//   one shift. A last column adds a further min scan before the result beat
//   is loaded into the output register. The scan carries the running minimum
//   one cell per cycle; a column beat is taken only when the block is idle.
// Reset: all states unreachable, next column starts a sequence, min_run = 1,
//   max_run = 64, no result pending.
// ----------------------------------------------------------------------------
// run_length_bounded_two_color_dp
// Column-by-column two-color segmentation with bounded run lengths, built as
// two rows of run-length cells plus a small sequencer.
// ----------------------------------------------------------------------------
module run_length_bounded_two_color_dp import rlbtc_pkg::*; #(
  parameter int unsigned MAX_RUN = 64,
  localparam int unsigned YW     = $clog2(MAX_RUN + 1),
  localparam int unsigned CNTW   = $clog2(MAX_RUN + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rlbtc_col_if.sink            col_i,
  rlbtc_res_if.source          res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  cfg_t                 cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN_PRE,
    ST_UPDATE,
    ST_SCAN_POST,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CNTW-1:0] cnt_q;
  logic            first_q;
  logic            last_q;
  in_cost_t        cw_q;
  in_cost_t        cb_q;
  cfg_t            min_run_q;
  cfg_t            max_run_q;
  logic            out_valid_q;
  cost_t           out_cost_q;
  logic            out_inf_q;

  logic [YW-1:0]   y;
  cell_ctrl_t      ctrl;
  cand_t           min_w;
  cand_t           min_b;
  cand_t           best;
  logic            col_acc;
  logic            out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q <= MIN_RUN_RESET;
      max_run_q <= MAX_RUN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_RUN: min_run_q <= cfg_data_i;
        CFG_MAX_RUN: max_run_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // clamp max_run to 1..MAX_RUN
  always_comb begin
    if (max_run_q == '0) begin
      y = YW'(1);
    end else if (32'(max_run_q) > 32'(MAX_RUN)) begin
      y = YW'(MAX_RUN);
    end else begin
      y = YW'(max_run_q);
    end
  end

  // drive the cell rows from the sequencer state
  assign ctrl.init  = (state_q == ST_INIT);
  assign ctrl.shift = (state_q == ST_UPDATE);
  assign ctrl.scan  = (state_q == ST_SCAN_PRE) || (state_q == ST_SCAN_POST);

  rlbtc_chain #(.MAX_RUN(MAX_RUN)) u_white (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .x_i          (min_run_q),
    .y_i          (y),
    .col_cost_i   (cw_q),
    .head_reach_i (~min_b[COST_W]),
    .head_cost_i  (min_b[COST_W-1:0]),
    .min_o        (min_w)
  );

  rlbtc_chain #(.MAX_RUN(MAX_RUN)) u_black (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .x_i          (min_run_q),
    .y_i          (y),
    .col_cost_i   (cb_q),
    .head_reach_i (~min_w[COST_W]),
    .head_cost_i  (min_w[COST_W-1:0]),
    .min_o        (min_b)
  );

  assign best     = (min_w < min_b) ? min_w : min_b;
  assign col_acc  = col_i.valid && col_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      first_q     <= 1'b1;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result beat, or drop the one taken
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (col_acc) begin
            last_q  <= col_i.last_column;
            cnt_q   <= CNTW'(MAX_RUN - 1);
            state_q <= first_q ? ST_INIT : ST_SCAN_PRE;
          end
        end
        ST_INIT: begin
          first_q <= 1'b0;
          cnt_q   <= CNTW'(MAX_RUN - 1);
          state_q <= last_q ? ST_SCAN_POST : ST_IDLE;
        end
        ST_SCAN_PRE: begin
          cnt_q <= cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          cnt_q   <= CNTW'(MAX_RUN - 1);
          state_q <= last_q ? ST_SCAN_POST : ST_IDLE;
        end
        ST_SCAN_POST: begin
          cnt_q <= cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            first_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // capture column costs and result payload
  always_ff @(posedge clk_i) begin
    if (col_acc) begin
      cw_q <= col_i.cost_white;
      cb_q <= col_i.cost_black;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_cost_q <= best[COST_W] ? '0 : best[COST_W-1:0];
      out_inf_q  <= best[COST_W];
    end
  end

  assign col_i.ready      = (state_q == ST_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.min_cost   = out_cost_q;
  assign res_o.infeasible = out_inf_q;

endmodule

// ===== rtl/rlbtc_cell.sv =====
// ----------------------------------------------------------------------------
// rlbtc_cell
// One run-length state of one color: holds cost and reachability, takes the
// neighbor's state on a column step and folds itself into the running min.
// ----------------------------------------------------------------------------
module rlbtc_cell import rlbtc_pkg::*; #(
  parameter int unsigned MAX_RUN = 64,
  parameter int unsigned LEN     = 1,
  localparam int unsigned YW     = $clog2(MAX_RUN + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cfg_t       x_i,
  input  logic [YW-1:0] y_i,
  input  in_cost_t   col_cost_i,
  input  logic       prev_reach_i,
  input  cost_t      prev_cost_i,
  input  cand_t      mc_i,
  output logic       reach_o,
  output cost_t      cost_o,
  output cand_t      mc_o
);

  logic  reach_q;
  cost_t cost_q;
  cand_t mc_q;
  logic  in_range;
  logic  fits;
  cand_t cand;

  // run length inside [min_run, max_run]
  assign fits     = 32'(LEN) <= 32'(y_i);
  assign in_range = (32'(LEN) >= 32'(x_i)) && fits;
  assign cand     = (reach_q && in_range) ? {1'b0, cost_q} : CAND_NONE;

  // hold the state, load the first column or advance one column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= 1'b0;
    end else if (ctrl_i.init) begin
      reach_q <= (LEN == 1);
    end else if (ctrl_i.shift) begin
      reach_q <= prev_reach_i && fits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      cost_q <= (LEN == 1) ? {{(COST_W - IN_COST_W){1'b0}}, col_cost_i} : '0;
    end else if (ctrl_i.shift) begin
      cost_q <= (prev_reach_i && fits) ? sat_add(prev_cost_i, col_cost_i) : '0;
    end
  end

  // pass the running minimum to the next cell
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan) begin
      mc_q <= (cand < mc_i) ? cand : mc_i;
    end
  end

  assign reach_o = reach_q;
  assign cost_o  = cost_q;
  assign mc_o    = mc_q;

endmodule

// ===== rtl/rlbtc_chain.sv =====
// ----------------------------------------------------------------------------
// rlbtc_chain
// Row of cells for one color, run length 1 at the head. The head takes the
// best switch from the other color; the tail gives the scanned minimum.
// ----------------------------------------------------------------------------
module rlbtc_chain import rlbtc_pkg::*; #(
  parameter int unsigned MAX_RUN = 64,
  localparam int unsigned YW     = $clog2(MAX_RUN + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctrl_t    ctrl_i,
  input  cfg_t          x_i,
  input  logic [YW-1:0] y_i,
  input  in_cost_t      col_cost_i,
  input  logic          head_reach_i,
  input  cost_t         head_cost_i,
  output cand_t         min_o
);

  logic  reach [MAX_RUN];
  cost_t cost  [MAX_RUN];
  cand_t mc    [MAX_RUN];

  // build the row
  for (genvar k = 0; k < MAX_RUN; k++) begin : g_cell
    logic  p_reach;
    cost_t p_cost;
    cand_t p_mc;

    if (k == 0) begin : g_head
      assign p_reach = head_reach_i;
      assign p_cost  = head_cost_i;
      assign p_mc    = CAND_NONE;
    end else begin : g_body
      assign p_reach = reach[k-1];
      assign p_cost  = cost[k-1];
      assign p_mc    = mc[k-1];
    end

    rlbtc_cell #(
      .MAX_RUN (MAX_RUN),
      .LEN     (k + 1)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .x_i          (x_i),
      .y_i          (y_i),
      .col_cost_i   (col_cost_i),
      .prev_reach_i (p_reach),
      .prev_cost_i  (p_cost),
      .mc_i         (p_mc),
      .reach_o      (reach[k]),
      .cost_o       (cost[k]),
      .mc_o         (mc[k])
    );
  end

  assign min_o = mc[MAX_RUN-1];

endmodule

// ===== rtl/rlbtc_checker.sv =====
// ----------------------------------------------------------------------------
// rlbtc_checker
// Port-level checks on the segmentation block, bound to the top level.
// ----------------------------------------------------------------------------
module rlbtc_checker import rlbtc_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  col_valid_i,
  input logic  col_ready_i,
  input logic  res_valid_i,
  input logic  res_ready_i,
  input cost_t res_min_cost_i,
  input logic  res_infeasible_i
);

  // result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped before taken");

  // infeasible result reports zero cost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_infeasible_i |-> res_min_cost_i == '0)
    else $error("infeasible result with nonzero cost");

  // a column beat is worked on before the next is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_valid_i && col_ready_i |=> !col_ready_i)
    else $error("column beat taken while busy");

  // a new result appears only after the block was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!col_ready_i))
    else $error("result beat without preceding work");

endmodule

bind run_length_bounded_two_color_dp rlbtc_checker u_rlbtc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .col_valid_i      (col_i.valid),
  .col_ready_i      (col_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_min_cost_i   (res_o.min_cost),
  .res_infeasible_i (res_o.infeasible)
);
